>>> rtl/core/pqfs_pkg.sv
package pqfs_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int FLIT_BYTES_DEF  = 16;

   localparam int NODE_W  = 8;
   localparam int CHAN_W  = 2;
   localparam int LEN_W   = 16;
   localparam int ADDR_W  = 32;
   localparam int STAMP_W = 32;
   localparam int SEQ_W   = 13;
   localparam int VB_W    = 5;
   localparam int KIND_W  = 2;
   localparam int LIMIT_W = 5;
   localparam int CSR_W   = 8;
   localparam int CSR_IDX_W = 1;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_SEND    = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_OWN_NODE    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUEUE_LIMIT = 1'b1;

   localparam logic [KIND_W-1:0] KIND_HEAD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BODY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TAIL = 2'd2;

   typedef struct packed {
      logic [NODE_W-1:0]  dest;
      logic [CHAN_W-1:0]  chan;
      logic               write;
      logic [LEN_W-1:0]   len;
      logic [ADDR_W-1:0]  addr;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic               valid;
      logic [KIND_W-1:0]  kind;
      logic [NODE_W-1:0]  dest;
      logic [CHAN_W-1:0]  chan;
      logic [SEQ_W-1:0]   seq_index;
      logic [SEQ_W-1:0]   seq_total;
      logic               write;
      logic [ADDR_W-1:0]  addr;
      logic [LEN_W-1:0]   len;
      logic [VB_W-1:0]    valid_bytes;
      logic [STAMP_W-1:0] stamp;
   } flit_word_type;

endpackage

>>> rtl/core/pqfs_ram.sv
module pqfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/pqfs_sizer.sv
module pqfs_sizer import pqfs_pkg::*; #(
   parameter int FLIT_BYTES = FLIT_BYTES_DEF,
   parameter int TOT_W      = 13
) (
   input  logic             is_write,
   input  logic [LEN_W-1:0] byte_len,
   output logic [TOT_W-1:0] total
);

   localparam int X_W   = LEN_W + 1;
   localparam int K     = $clog2(FLIT_BYTES);
   localparam int S     = X_W + K;
   localparam int M_W   = X_W + 1;
   localparam int RECIP_INT = (2 ** S + FLIT_BYTES - 1) / FLIT_BYTES;
   localparam logic [M_W-1:0] RECIP = M_W'(RECIP_INT);
   localparam int P_W   = X_W + M_W;

   logic [X_W-1:0] padded;
   logic [P_W-1:0] prod;
   logic [X_W-1:0] body;

   assign padded = {1'b0, byte_len} + X_W'(FLIT_BYTES - 1);
   assign prod   = P_W'(padded) * P_W'(RECIP);
   assign body   = X_W'(prod >> S);
   assign total  = (is_write ? TOT_W'(body) : TOT_W'(0)) + TOT_W'(2);

endmodule

>>> rtl/core/pqfs_framer.sv
module pqfs_framer import pqfs_pkg::*; #(
   parameter int FLIT_BYTES = FLIT_BYTES_DEF,
   parameter int TOT_W      = 13,
   parameter int OFF_W      = LEN_W + 1
) (
   input  entry_type        entry,
   input  logic [TOT_W-1:0] total,
   input  logic [TOT_W-1:0] remaining,
   input  logic [OFF_W-1:0] offset,
   output flit_word_type    flit,
   output logic [TOT_W-1:0] remaining_next,
   output logic [OFF_W-1:0] offset_next,
   output logic             pop
);

   logic [TOT_W-1:0]  rem_eff;
   logic [TOT_W-1:0]  seq;
   logic [KIND_W-1:0] kind;
   logic              is_body;
   logic [OFF_W-1:0]  rest;
   logic [OFF_W-1:0]  vb;

   always_comb begin
      rem_eff = (remaining == '0) ? total : remaining;
      seq     = total - rem_eff;
      if (rem_eff == total) begin
         kind = KIND_HEAD;
      end else if (rem_eff == TOT_W'(1)) begin
         kind = KIND_TAIL;
      end else begin
         kind = KIND_BODY;
      end
      is_body = (kind == KIND_BODY);
      rest    = OFF_W'(entry.len) - offset;
      if (!is_body) begin
         vb = '0;
      end else if (rest < OFF_W'(FLIT_BYTES)) begin
         vb = rest;
      end else begin
         vb = OFF_W'(FLIT_BYTES);
      end

      flit.valid       = 1'b1;
      flit.kind        = kind;
      flit.dest        = entry.dest;
      flit.chan        = entry.chan;
      flit.seq_index   = SEQ_W'(seq);
      flit.seq_total   = SEQ_W'(total);
      flit.write       = entry.write;
      flit.addr        = entry.addr + (is_body ? ADDR_W'(offset) : ADDR_W'(0));
      flit.len         = entry.len;
      flit.valid_bytes = VB_W'(vb);
      flit.stamp       = entry.stamp;

      remaining_next = rem_eff - TOT_W'(1);
      pop            = (rem_eff == TOT_W'(1));
      if (kind == KIND_HEAD) begin
         offset_next = '0;
      end else if (is_body) begin
         offset_next = offset + OFF_W'(FLIT_BYTES);
      end else begin
         offset_next = offset;
      end
   end

endmodule

>>> rtl/core/packet_queue_flit_segmenter.sv
// A taken start moves the state register to a work state, which sets registered rsp_strobe,
// high for one cycle. Start is refused while busy; busy covers the work state, in which the
// packet queue memory (one write port, one registered read port) is written or its read used.
// Reset: synchronous, active high; clears pointers, occupancy, flit progress and own node;
// limit CSR resets to 16. Queue memory is not cleared. The receiver cannot stall rsp_strobe.
module packet_queue_flit_segmenter import pqfs_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int FLIT_BYTES  = FLIT_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 start,
   output logic                 busy,
   input  logic                 req_op,
   input  logic                 req_is_write,
   input  logic [NODE_W-1:0]    req_dest_node,
   input  logic [NODE_W-1:0]    req_mem_node,
   input  logic [ADDR_W-1:0]    req_base_addr,
   input  logic [LEN_W-1:0]     req_byte_len,
   input  logic [CHAN_W-1:0]    req_chan,
   input  logic [STAMP_W-1:0]   req_stamp,

   output logic                 rsp_strobe,
   output logic                 rsp_status,
   output logic                 rsp_flit_valid,
   output logic [KIND_W-1:0]    rsp_flit_kind,
   output logic [NODE_W-1:0]    rsp_flit_dest,
   output logic [CHAN_W-1:0]    rsp_flit_chan,
   output logic [SEQ_W-1:0]     rsp_seq_index,
   output logic [SEQ_W-1:0]     rsp_seq_total,
   output logic                 rsp_flit_write,
   output logic [ADDR_W-1:0]    rsp_flit_addr,
   output logic [LEN_W-1:0]     rsp_flit_len,
   output logic [VB_W-1:0]      rsp_valid_bytes,
   output logic [STAMP_W-1:0]   rsp_flit_stamp,

   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int PTR_W    = $clog2(QUEUE_DEPTH);
   localparam int OCC_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W    = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;
   localparam int BODY_MAX = ((1 << LEN_W) - 1 + FLIT_BYTES - 1) / FLIT_BYTES;
   localparam int TOT_W    = $clog2(BODY_MAX + 3);
   localparam int OFF_W    = LEN_W + 1;
   localparam int RAM_W    = $bits(entry_type) + TOT_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ENQ  = 2'd1;
   localparam logic [1:0] ST_SEND = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [PTR_W-1:0]   read_ptr_ff, read_ptr_in;
   logic [PTR_W-1:0]   write_ptr_ff, write_ptr_in;
   logic [OCC_W-1:0]   occupancy_ff, occupancy_in;
   logic [TOT_W-1:0]   remaining_ff, remaining_in;
   logic [OFF_W-1:0]   offset_ff, offset_in;
   logic [NODE_W-1:0]  own_node_ff;
   logic [LIMIT_W-1:0] queue_limit_ff;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic               rsp_status_ff, rsp_status_in;
   flit_word_type      rsp_flit_ff, rsp_flit_in;
   entry_type          req_ff, req_in;

   logic               accept;
   logic               full;
   logic [TOT_W-1:0]   enq_total;
   logic               ram_we;
   logic [RAM_W-1:0]   ram_rd_data;
   entry_type          rd_entry;
   logic [TOT_W-1:0]   rd_total;
   flit_word_type      framed;
   logic [TOT_W-1:0]   remaining_next;
   logic [OFF_W-1:0]   offset_next;
   logic               pop;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      req_in.dest  = (req_mem_node != '0) ? req_mem_node : req_dest_node;
      req_in.chan  = req_chan;
      req_in.write = req_is_write;
      req_in.len   = req_byte_len;
      req_in.addr  = req_base_addr;
      req_in.stamp = req_stamp;
   end

   pqfs_sizer #(
      .FLIT_BYTES (FLIT_BYTES),
      .TOT_W      (TOT_W)
   ) u_sizer (
      .is_write (req_ff.write),
      .byte_len (req_ff.len),
      .total    (enq_total)
   );

   assign full = (occupancy_ff >= OCC_W'(QUEUE_DEPTH)) ||
                 (CMP_W'(occupancy_ff) >= CMP_W'(queue_limit_ff));
   assign ram_we = (state_ff == ST_ENQ) && !full;

   pqfs_ram #(
      .WIDTH (RAM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (write_ptr_ff),
      .wr_data ({req_ff, enq_total}),
      .rd_addr (read_ptr_ff),
      .rd_data (ram_rd_data)
   );

   assign rd_entry = entry_type'(ram_rd_data[RAM_W-1:TOT_W]);
   assign rd_total = ram_rd_data[TOT_W-1:0];

   pqfs_framer #(
      .FLIT_BYTES (FLIT_BYTES),
      .TOT_W      (TOT_W),
      .OFF_W      (OFF_W)
   ) u_framer (
      .entry          (rd_entry),
      .total          (rd_total),
      .remaining      (remaining_ff),
      .offset         (offset_ff),
      .flit           (framed),
      .remaining_next (remaining_next),
      .offset_next    (offset_next),
      .pop            (pop)
   );

   always_comb begin
      state_in      = state_ff;
      read_ptr_in   = read_ptr_ff;
      write_ptr_in  = write_ptr_ff;
      occupancy_in  = occupancy_ff;
      remaining_in  = remaining_ff;
      offset_in     = offset_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = 1'b0;
      rsp_flit_in   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_op == OP_SEND) ? ST_SEND : ST_ENQ;
            end
         end
         ST_ENQ: begin
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_status_in = full;
            if (!full) begin
               write_ptr_in = (write_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : write_ptr_ff + PTR_W'(1);
               occupancy_in = occupancy_ff + OCC_W'(1);
            end
         end
         ST_SEND: begin
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
            if (occupancy_ff != '0) begin
               rsp_flit_in  = framed;
               remaining_in = remaining_next;
               offset_in    = offset_next;
               if (pop) begin
                  read_ptr_in  = (read_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ?
                                 '0 : read_ptr_ff + PTR_W'(1);
                  occupancy_in = occupancy_ff - OCC_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         read_ptr_ff    <= '0;
         write_ptr_ff   <= '0;
         occupancy_ff   <= '0;
         remaining_ff   <= '0;
         offset_ff      <= '0;
         rsp_strobe_ff  <= 1'b0;
         own_node_ff    <= '0;
         queue_limit_ff <= LIMIT_RESET;
      end else begin
         state_ff      <= state_in;
         read_ptr_ff   <= read_ptr_in;
         write_ptr_ff  <= write_ptr_in;
         occupancy_ff  <= occupancy_in;
         remaining_ff  <= remaining_in;
         offset_ff     <= offset_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_we) begin
            case (csr_index)
               CSR_OWN_NODE:    own_node_ff    <= csr_wdata;
               CSR_QUEUE_LIMIT: queue_limit_ff <= csr_wdata[LIMIT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_flit_ff   <= rsp_flit_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_flit_valid  = rsp_flit_ff.valid;
   assign rsp_flit_kind   = rsp_flit_ff.kind;
   assign rsp_flit_dest   = rsp_flit_ff.dest;
   assign rsp_flit_chan   = rsp_flit_ff.chan;
   assign rsp_seq_index   = rsp_flit_ff.seq_index;
   assign rsp_seq_total   = rsp_flit_ff.seq_total;
   assign rsp_flit_write  = rsp_flit_ff.write;
   assign rsp_flit_addr   = rsp_flit_ff.addr;
   assign rsp_flit_len    = rsp_flit_ff.len;
   assign rsp_valid_bytes = rsp_flit_ff.valid_bytes;
   assign rsp_flit_stamp  = rsp_flit_ff.stamp;

   a_occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      occupancy_ff <= OCC_W'(QUEUE_DEPTH))
      else $error("occupancy above queue depth");

   a_strobe_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> ($past(state_ff) == ST_ENQ || $past(state_ff) == ST_SEND))
      else $error("result strobe without a work cycle");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted transaction did not raise busy");

   a_flit_not_refused: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_flit_ff.valid) |-> !rsp_status_ff)
      else $error("flit carried a refusal status");

endmodule
